/* hw/rtl/spf_pkg.sv */
// Package: shared types and constants for the servo packet framer.
`default_nettype none

package spf_pkg;

  localparam int DEFAULT_MAX_PAYLOAD = 32;

  localparam int CFG_IDX_W = 8;
  localparam int BYTE_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SERVO_ID = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JOG_CMD  = 8'd1;

  localparam logic [BYTE_W-1:0] RESET_SERVO_ID = 8'h00;
  localparam logic [BYTE_W-1:0] RESET_JOG_CMD  = 8'h05;

  localparam logic FUNC_PAYLOAD = 1'b0;
  localparam logic FUNC_JOG     = 1'b1;

  localparam logic [BYTE_W-1:0] SYNC_BYTE      = 8'hFF;
  localparam logic [BYTE_W-1:0] CHECK_MASK     = 8'hFE;
  localparam logic [BYTE_W-1:0] FRAME_OVERHEAD = 8'd7;
  localparam logic [BYTE_W-1:0] JOG_LEN        = 8'd5;

  // Byte positions within the frame header.
  localparam logic [BYTE_W-1:0] BYTE_SYNC0  = 8'd0;
  localparam logic [BYTE_W-1:0] BYTE_SYNC1  = 8'd1;
  localparam logic [BYTE_W-1:0] BYTE_SIZE   = 8'd2;
  localparam logic [BYTE_W-1:0] BYTE_ID     = 8'd3;
  localparam logic [BYTE_W-1:0] BYTE_CMD    = 8'd4;
  localparam logic [BYTE_W-1:0] BYTE_CHECK1 = 8'd5;
  localparam logic [BYTE_W-1:0] BYTE_CHECK2 = 8'd6;

  // Jog data byte positions.
  localparam logic [2:0] JOG_POS_LO = 3'd0;
  localparam logic [2:0] JOG_POS_HI = 3'd1;
  localparam logic [2:0] JOG_LED    = 3'd2;
  localparam logic [2:0] JOG_ID     = 3'd3;
  localparam logic [2:0] JOG_TIME   = 3'd4;

  typedef struct packed {
    logic accept;
    logic emit;
  } spf_cmd_t;

  typedef struct packed {
    logic frame_req;
    logic out_free;
    logic last_byte;
  } spf_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/spf_if.sv */
// Interfaces: input item, result byte and configuration write channels.
`default_nettype none

interface spf_in_if;
  logic              valid;
  logic              ready;
  logic              func;
  logic [7:0]        command_code;
  logic [7:0]        payload_byte;
  logic              end_of_payload;
  logic signed [14:0] position;
  logic [7:0]        play_time;
  logic [2:0]        led_color;

  modport source (output valid, func, command_code, payload_byte, end_of_payload,
                  position, play_time, led_color, input ready);
  modport sink   (input valid, func, command_code, payload_byte, end_of_payload,
                  position, play_time, led_color, output ready);
endinterface

interface spf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       frame_end;

  modport source (output valid, tx_byte, frame_end, input ready);
  modport sink   (input valid, tx_byte, frame_end, output ready);
endinterface

interface spf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/servo_packet_framer_core.sv */
// Top level: servo command packet framer with XOR checksum.
//
//   channel | dir | contents
//   in_ch   | in  | func, command_code, payload_byte, end_of_payload, position,
//           |     | play_time, led_color
//   out_ch  | out | tx_byte, frame_end (one frame byte per transfer)
//   cfg_ch  | in  | index, data (0 servo_id, 1 jog_command_code), always ready
//
// A payload byte without end of payload leaves input ready. An item that sends a
// frame blocks input for 7 + n byte transfers, one per cycle when out_ch is
// ready; the output register sets the pace. Reset is synchronous, active low,
// and clears the buffer count and checksum. Output stalls hold the sequencer.
`default_nettype none

module servo_packet_framer_core #(
  parameter int MAX_PAYLOAD = spf_pkg::DEFAULT_MAX_PAYLOAD
) (
  input wire logic clk,
  input wire logic rst_n,
  spf_in_if.sink   in_ch,
  spf_out_if.source out_ch,
  spf_cfg_if.sink  cfg_ch
);
  import spf_pkg::*;

  spf_cmd_t cmd;
  spf_sts_t sts;
  logic     in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  spf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spf_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_ch.func),
    .in_command_code   (in_ch.command_code),
    .in_payload_byte   (in_ch.payload_byte),
    .in_end_of_payload (in_ch.end_of_payload),
    .in_position       (in_ch.position),
    .in_play_time      (in_ch.play_time),
    .in_led_color      (in_ch.led_color),
    .cfg_we            (cfg_ch.valid),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_tx_byte       (out_ch.tx_byte),
    .out_frame_end     (out_ch.frame_end)
  );

endmodule

`default_nettype wire

/* hw/rtl/spf_ctrl.sv */
// Controller: input acceptance and frame send sequencing.
`default_nettype none

module spf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire spf_pkg::spf_sts_t sts,
  output spf_pkg::spf_cmd_t      cmd
);
  import spf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    cmd.accept = in_ready && in_valid;
    cmd.emit   = (state_r == ST_SEND) && sts.out_free;
    state_nxt  = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept && sts.frame_req) state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (cmd.emit && sts.last_byte) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

/* hw/rtl/spf_datapath.sv */
// Datapath: payload buffer, checksum, config registers and frame byte output.
`default_nettype none

module spf_datapath #(
  parameter int MAX_PAYLOAD = spf_pkg::DEFAULT_MAX_PAYLOAD
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire spf_pkg::spf_cmd_t cmd,
  output spf_pkg::spf_sts_t      sts,
  input  wire logic              in_func,
  input  wire logic [7:0]        in_command_code,
  input  wire logic [7:0]        in_payload_byte,
  input  wire logic              in_end_of_payload,
  input  wire logic [14:0]       in_position,
  input  wire logic [7:0]        in_play_time,
  input  wire logic [2:0]        in_led_color,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_index,
  input  wire logic [7:0]        cfg_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_tx_byte,
  output logic                   out_frame_end
);
  import spf_pkg::*;

  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam int AW = $clog2(MAX_PAYLOAD);

  logic [7:0]    mem [MAX_PAYLOAD];
  logic [7:0]    rd_data_r;

  logic [7:0]    servo_id_r, jog_cmd_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    xor_r, xor_nxt;

  logic [7:0]    frame_cmd_r, frame_xor_r;
  logic [CW-1:0] frame_len_r;
  logic          is_jog_r;
  logic [7:0]    jog_r [5];
  logic [7:0]    byte_idx_r;
  logic [CW-1:0] data_ptr_r, data_ptr_nxt;

  logic          out_valid_r;
  logic [7:0]    tx_byte_r;
  logic          frame_end_r;

  logic          wr_en, start;
  logic [7:0]    jog_b [5];
  logic [7:0]    jog_xor;
  logic [7:0]    size_byte, check1, check2, jog_sel, cur_byte;
  logic          data_phase, cur_end;

  always_comb begin
    jog_b[JOG_POS_LO] = in_position[7:0];
    jog_b[JOG_POS_HI] = {1'b0, in_position[14], in_position[13:8]};
    jog_b[JOG_LED]    = {3'b000, in_led_color, 2'b00};
    jog_b[JOG_ID]     = servo_id_r;
    jog_b[JOG_TIME]   = in_play_time;
    jog_xor = jog_b[0] ^ jog_b[1] ^ jog_b[2] ^ jog_b[3] ^ jog_b[4];

    wr_en     = cmd.accept && (in_func == FUNC_PAYLOAD) && (count_r < CW'(MAX_PAYLOAD));
    count_nxt = wr_en ? count_r + CW'(1) : count_r;
    xor_nxt   = wr_en ? (xor_r ^ in_payload_byte) : xor_r;
    start     = cmd.accept && ((in_func == FUNC_JOG) || in_end_of_payload);

    size_byte = FRAME_OVERHEAD + 8'(frame_len_r);
    check1    = (size_byte ^ servo_id_r ^ frame_cmd_r ^ frame_xor_r) & CHECK_MASK;
    check2    = (~check1) & CHECK_MASK;

    case (data_ptr_r[2:0])
      JOG_POS_LO: jog_sel = jog_r[0];
      JOG_POS_HI: jog_sel = jog_r[1];
      JOG_LED:    jog_sel = jog_r[2];
      JOG_ID:     jog_sel = jog_r[3];
      JOG_TIME:   jog_sel = jog_r[4];
      default:    jog_sel = jog_r[0];
    endcase

    data_phase = (byte_idx_r > BYTE_CHECK2);
    case (byte_idx_r)
      BYTE_SYNC0:  cur_byte = SYNC_BYTE;
      BYTE_SYNC1:  cur_byte = SYNC_BYTE;
      BYTE_SIZE:   cur_byte = size_byte;
      BYTE_ID:     cur_byte = servo_id_r;
      BYTE_CMD:    cur_byte = frame_cmd_r;
      BYTE_CHECK1: cur_byte = check1;
      BYTE_CHECK2: cur_byte = check2;
      default:     cur_byte = is_jog_r ? jog_sel : rd_data_r;
    endcase

    sts.last_byte = (byte_idx_r == BYTE_CHECK2 + 8'(frame_len_r));
    cur_end       = sts.last_byte || ((byte_idx_r == BYTE_CHECK1) && (frame_len_r == '0));
    sts.out_free  = !out_valid_r || out_ready;
    sts.frame_req = (in_func == FUNC_JOG) || in_end_of_payload;

    if (start)                        data_ptr_nxt = '0;
    else if (cmd.emit && data_phase)  data_ptr_nxt = data_ptr_r + CW'(1);
    else                              data_ptr_nxt = data_ptr_r;
  end

  // Buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[count_r[AW-1:0]] <= in_payload_byte;
    rd_data_r <= mem[data_ptr_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_id_r  <= RESET_SERVO_ID;
      jog_cmd_r   <= RESET_JOG_CMD;
      count_r     <= '0;
      xor_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == REG_SERVO_ID)) servo_id_r <= cfg_data;
      if (cfg_we && (cfg_index == REG_JOG_CMD))  jog_cmd_r  <= cfg_data;
      if (start && (in_func == FUNC_PAYLOAD)) begin
        count_r <= '0;
        xor_r   <= '0;
      end else begin
        count_r <= count_nxt;
        xor_r   <= xor_nxt;
      end
      if (cmd.emit)      out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    data_ptr_r <= data_ptr_nxt;
    if (start) begin
      byte_idx_r <= '0;
      if (in_func == FUNC_JOG) begin
        is_jog_r    <= 1'b1;
        frame_cmd_r <= jog_cmd_r;
        frame_len_r <= CW'(JOG_LEN);
        frame_xor_r <= jog_xor;
        for (int i = 0; i < 5; i++) jog_r[i] <= jog_b[i];
      end else begin
        is_jog_r    <= 1'b0;
        frame_cmd_r <= in_command_code;
        frame_len_r <= count_nxt;
        frame_xor_r <= xor_nxt;
      end
    end else if (cmd.emit) begin
      byte_idx_r <= byte_idx_r + 8'd1;
    end
    if (cmd.emit) begin
      tx_byte_r   <= cur_byte;
      frame_end_r <= cur_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = tx_byte_r;
  assign out_frame_end = frame_end_r;

endmodule

`default_nettype wire

/* tb/sv/tb_servo_packet_framer_core.sv */
`timescale 1ns / 100ps
// Testbench: servo packet framer byte stream checked against a frame predictor.
module tb_servo_packet_framer_core;
  import spf_pkg::*;

  localparam int PAYLOAD_CAP      = DEFAULT_MAX_PAYLOAD;
  localparam int RANDOM_PER_PHASE = 56;
  localparam int SETTLE_CYCLES    = 12;
  localparam int CYCLE_LIMIT      = 1000000;

  typedef struct {
    logic               func;
    logic [7:0]         command_code;
    logic [7:0]         payload_byte;
    logic               end_of_payload;
    logic signed [14:0] position;
    logic [7:0]         play_time;
    logic [2:0]         led_color;
  } servo_req_t;

  typedef struct {
    logic [7:0] tx_byte;
    logic       frame_end;
  } frame_byte_t;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic clk;
  logic rst_n;

  spf_in_if  in_if();
  spf_out_if out_if();
  spf_cfg_if cfg_if();

  servo_packet_framer_core #(.MAX_PAYLOAD(PAYLOAD_CAP)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  servo_req_t  pending_reqs[$];
  frame_byte_t tx_expected[$];
  servo_req_t  next_req;
  servo_req_t  seen_req;
  frame_byte_t want;

  logic [7:0] model_servo_id = RESET_SERVO_ID;
  logic [7:0] model_jog_cmd  = RESET_JOG_CMD;
  logic [7:0] model_payload[$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned gap_left    = 0;
  int unsigned mode_left   = 0;
  logic [2:0]  stall_phase = '0;
  rx_mode_e    rx_mode     = RX_STEADY;

  function automatic servo_req_t random_req(input logic func, input logic eop);
    servo_req_t req;
    int pos;
    pos = int'($urandom_range(0, 24575)) - 8192;
    req.func           = func;
    req.command_code   = 8'($urandom);
    req.payload_byte   = 8'($urandom);
    req.end_of_payload = eop;
    req.position       = pos[14:0];
    req.play_time      = 8'($urandom);
    req.led_color      = 3'($urandom);
    return req;
  endfunction

  task automatic emit_frame_bytes(input logic [7:0] cmd, input logic [7:0] body[$]);
    logic [7:0] size_byte;
    logic [7:0] body_xor;
    logic [7:0] check1;
    logic       no_body;
    size_byte = FRAME_OVERHEAD + 8'(body.size());
    body_xor  = '0;
    foreach (body[i]) body_xor ^= body[i];
    check1  = (size_byte ^ model_servo_id ^ cmd ^ body_xor) & CHECK_MASK;
    no_body = (body.size() == 0);
    tx_expected.push_back(frame_byte_t'{SYNC_BYTE, 1'b0});
    tx_expected.push_back(frame_byte_t'{SYNC_BYTE, 1'b0});
    tx_expected.push_back(frame_byte_t'{size_byte, 1'b0});
    tx_expected.push_back(frame_byte_t'{model_servo_id, 1'b0});
    tx_expected.push_back(frame_byte_t'{cmd, 1'b0});
    tx_expected.push_back(frame_byte_t'{check1, no_body});
    tx_expected.push_back(frame_byte_t'{~check1 & CHECK_MASK, no_body});
    foreach (body[i]) tx_expected.push_back(frame_byte_t'{body[i], i == body.size() - 1});
  endtask

  task automatic predict_transfer(input servo_req_t req);
    logic [7:0] jog_body[$];
    if (req.func == FUNC_JOG) begin
      jog_body = '{req.position[7:0],
                   {1'b0, req.position[14], req.position[13:8]},
                   {3'b000, req.led_color, 2'b00},
                   model_servo_id,
                   req.play_time};
      emit_frame_bytes(model_jog_cmd, jog_body);
    end else begin
      if (model_payload.size() < PAYLOAD_CAP) model_payload.push_back(req.payload_byte);
      if (req.end_of_payload) begin
        emit_frame_bytes(req.command_code, model_payload);
        model_payload.delete();
      end
    end
  endtask

  task automatic add_random_reqs(input int unsigned target, input bit long_first);
    int unsigned added;
    int unsigned len;
    int unsigned jog_at;
    int unsigned sel;
    int unsigned noise;
    added = 0;
    while (added < target) begin
      sel = $urandom_range(0, 99);
      if (long_first || sel < 55) begin
        if (long_first) len = 34;
        else if ($urandom_range(0, 9) < 7) len = $urandom_range(1, 6);
        else if ($urandom_range(0, 2) != 0) len = $urandom_range(7, 31);
        else len = $urandom_range(32, 40);
        long_first = 1'b0;
        jog_at = (len >= 2 && $urandom_range(0, 4) == 0) ? $urandom_range(2, len) : 0;
        for (int i = 1; i <= len; i++) begin
          if (i == jog_at) begin
            pending_reqs.push_back(random_req(FUNC_JOG, 1'($urandom)));
            added++;
          end
          pending_reqs.push_back(random_req(FUNC_PAYLOAD, i == len));
          added++;
        end
      end else if (sel < 90) begin
        pending_reqs.push_back(random_req(FUNC_JOG, 1'($urandom)));
        added++;
      end else begin
        noise = $urandom_range(1, 3);
        repeat (noise) pending_reqs.push_back(random_req(FUNC_PAYLOAD, 1'b0));
        added += noise;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // Sampled mid-cycle so the sender's updates at the edge have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_if.valid || tx_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d bytes still expected", $time, tx_expected.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sender: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid          <= 1'b0;
      in_if.func           <= FUNC_PAYLOAD;
      in_if.command_code   <= '0;
      in_if.payload_byte   <= '0;
      in_if.end_of_payload <= 1'b0;
      in_if.position       <= '0;
      in_if.play_time      <= '0;
      in_if.led_color      <= '0;
      burst_left           <= 0;
      gap_left             <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left != 0) begin
        gap_left    <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        in_if.valid          <= 1'b1;
        in_if.func           <= next_req.func;
        in_if.command_code   <= next_req.command_code;
        in_if.payload_byte   <= next_req.payload_byte;
        in_if.end_of_payload <= next_req.end_of_payload;
        in_if.position       <= next_req.position;
        in_if.play_time      <= next_req.play_time;
        in_if.led_color      <= next_req.led_color;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern switches between modes of random length.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_mode      <= RX_STEADY;
      mode_left    <= 0;
      stall_phase  <= '0;
    end else begin
      stall_phase <= stall_phase + 3'd1;
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(16, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_STEADY: out_if.ready <= 1'b1;
        RX_COIN:   out_if.ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_if.ready <= (stall_phase == 3'd0);
        default:   out_if.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Monitor: tracks register writes and input transfers, checks output bytes.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_SERVO_ID: model_servo_id = cfg_if.data;
          REG_JOG_CMD:  model_jog_cmd  = cfg_if.data;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        seen_req.func           = in_if.func;
        seen_req.command_code   = in_if.command_code;
        seen_req.payload_byte   = in_if.payload_byte;
        seen_req.end_of_payload = in_if.end_of_payload;
        seen_req.position       = in_if.position;
        seen_req.play_time      = in_if.play_time;
        seen_req.led_color      = in_if.led_color;
        predict_transfer(seen_req);
      end
      if (out_if.valid && out_if.ready) begin
        if (tx_expected.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected byte: expected none, got tx_byte %h frame_end %b",
                   $time, out_if.tx_byte, out_if.frame_end);
        end else begin
          want = tx_expected.pop_front();
          if (out_if.tx_byte !== want.tx_byte) begin
            mismatches++;
            $display("%0t: tx_byte mismatch: expected %h, got %h",
                     $time, want.tx_byte, out_if.tx_byte);
          end
          if (out_if.frame_end !== want.frame_end) begin
            mismatches++;
            $display("%0t: frame_end mismatch: expected %b, got %b",
                     $time, want.frame_end, out_if.frame_end);
          end
        end
      end
    end
  end

  initial begin
    servo_req_t req;
    logic [7:0] id_val;
    logic [7:0] cmd_val;

    rst_n        = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_SERVO_ID;
    cfg_if.data  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset register values.
    req = random_req(FUNC_PAYLOAD, 1'b1);
    req.payload_byte = 8'h00;
    req.command_code = 8'h00;
    pending_reqs.push_back(req);
    req = random_req(FUNC_PAYLOAD, 1'b1);
    req.payload_byte = 8'hFF;
    req.command_code = 8'hFF;
    pending_reqs.push_back(req);
    req = random_req(FUNC_JOG, 1'b0);
    req.position  = 15'sd16383;
    req.led_color = 3'd7;
    req.play_time = 8'hFF;
    pending_reqs.push_back(req);
    req = random_req(FUNC_JOG, 1'b1);
    req.position  = -15'sd8192;
    req.led_color = 3'd0;
    req.play_time = 8'h00;
    pending_reqs.push_back(req);
    req = random_req(FUNC_JOG, 1'b0);
    req.position = -15'sd1;
    pending_reqs.push_back(req);
    req = random_req(FUNC_JOG, 1'b1);
    req.position = '0;
    pending_reqs.push_back(req);
    // jog lands while payload bytes are pending
    pending_reqs.push_back(random_req(FUNC_PAYLOAD, 1'b0));
    pending_reqs.push_back(random_req(FUNC_PAYLOAD, 1'b0));
    pending_reqs.push_back(random_req(FUNC_JOG, 1'b1));
    pending_reqs.push_back(random_req(FUNC_PAYLOAD, 1'b1));
    for (int i = 0; i < 4; i++) begin
      req = random_req(FUNC_PAYLOAD, i == 3);
      req.payload_byte = (i % 2 == 0) ? 8'hAA : 8'h55;
      req.command_code = 8'h80;
      pending_reqs.push_back(req);
    end
    add_random_reqs(RANDOM_PER_PHASE, 1'b1);
    wait_idle();

    for (int ph = 1; ph < 6; ph++) begin
      case (ph)
        1: begin
          id_val  = 8'hFF;
          cmd_val = 8'hFF;
        end
        2: begin
          id_val  = 8'h00;
          cmd_val = 8'h00;
        end
        4: begin
          id_val  = 8'h01;
          cmd_val = 8'h80;
        end
        default: begin
          id_val  = 8'($urandom);
          cmd_val = 8'($urandom);
        end
      endcase
      write_reg(REG_SERVO_ID, id_val);
      write_reg(REG_JOG_CMD, cmd_val);
      @(negedge clk);
      add_random_reqs(RANDOM_PER_PHASE, ph == 3);
      wait_idle();
    end

    if (tx_expected.size() != 0) begin
      mismatches++;
      $display("%0t: %0d bytes never arrived, first expected %h, got none",
               $time, tx_expected.size(), tx_expected[0].tx_byte);
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
